/* rtl/core/ccrc_pkg.sv */
// Shared constants and types for the configurable CRC remainder core.
`default_nettype none
package ccrc_pkg;

   localparam int MAX_DEGREE   = 32;
   localparam int REM_WIDTH    = MAX_DEGREE;
   localparam int TOP_IDX_W    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;
   localparam int DEG_W        = 6;
   localparam int LOW_BITS_W   = 32;
   localparam int RSP_REM_W    = 32;

   localparam logic [DEG_W-1:0]      DEGREE_RESET   = DEG_W'(3);
   localparam logic [LOW_BITS_W-1:0] LOW_BITS_RESET = LOW_BITS_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLY_DEGREE   = 1'b0,
      CSR_POLY_LOW_BITS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TOP_IDX_W-1:0] top_idx;
      logic [REM_WIDTH-1:0] mask;
      logic [REM_WIDTH-1:0] poly;
   } poly_cfg_type;

endpackage
`default_nettype wire

/* rtl/core/ccrc_csr.sv */
// Configuration registers and derived polynomial controls.
`default_nettype none
module ccrc_csr
   import ccrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output poly_cfg_type               cfg
);

   logic [DEG_W-1:0]      degree_ff;
   logic [DEG_W-1:0]      degree_in;
   logic [LOW_BITS_W-1:0] low_bits_ff;
   logic [LOW_BITS_W-1:0] low_bits_in;
   logic [DEG_W:0]        eff_deg;

   always_comb begin
      degree_in   = degree_ff;
      low_bits_in = low_bits_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_POLY_DEGREE:   degree_in   = wr_data[DEG_W-1:0];
            CSR_POLY_LOW_BITS: low_bits_in = wr_data[LOW_BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff   <= DEGREE_RESET;
         low_bits_ff <= LOW_BITS_RESET;
      end else begin
         degree_ff   <= degree_in;
         low_bits_ff <= low_bits_in;
      end
   end

   // clamp degree into 1..MAX_DEGREE
   always_comb begin
      eff_deg = {1'b0, degree_ff};
      if (eff_deg == '0) begin
         eff_deg = (DEG_W+1)'(1);
      end else if (eff_deg > (DEG_W+1)'(MAX_DEGREE)) begin
         eff_deg = (DEG_W+1)'(MAX_DEGREE);
      end
   end

   always_comb begin
      cfg.top_idx = TOP_IDX_W'(eff_deg - (DEG_W+1)'(1));
      for (int i = 0; i < REM_WIDTH; i++) begin
         cfg.mask[i] = (DEG_W+1)'(i) < eff_deg;
      end
      cfg.poly = REM_WIDTH'(low_bits_ff) & cfg.mask;
   end

endmodule
`default_nettype wire

/* rtl/core/ccrc_step.sv */
// Unrolled eight bit-step remainder update, MSB of the byte first.
`default_nettype none
module ccrc_step
   import ccrc_pkg::*;
(
   input  wire poly_cfg_type          cfg,
   input  wire logic [REM_WIDTH-1:0]  rem_i,
   input  wire logic [7:0]            data_byte,
   output logic      [REM_WIDTH-1:0]  rem_o
);

   logic [REM_WIDTH-1:0] r;
   logic                 top;

   always_comb begin
      r = rem_i & cfg.mask;
      for (int b = 7; b >= 0; b--) begin
         top = r[cfg.top_idx];
         r   = (r << 1) & cfg.mask;
         if (top ^ data_byte[b]) begin
            r = r ^ cfg.poly;
         end
      end
      rem_o = r;
   end

endmodule
`default_nettype wire

/* rtl/core/configurable_crc_remainder_core.sv */
// Top level of the configurable CRC remainder core.
// Pipeline: a beat is held in the input register, its result in the output one.
// Throughput: one beat per cycle without rsp_stall; unrolled 8-step byte update.
// Reset: synchronous, active high; clears the running remainder and both
// pipeline valids, and loads degree 3 with low bits 3 (x^3 + x + 1).
`default_nettype none
module configurable_crc_remainder_core
   import ccrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [RSP_REM_W-1:0]       rsp_remainder,
   output logic                       rsp_is_final,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   poly_cfg_type          cfg;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [REM_WIDTH-1:0]  out_rem_ff;
   logic                  out_final_ff;
   logic [REM_WIDTH-1:0]  rem_ff;
   logic [REM_WIDTH-1:0]  rem_in;
   logic [REM_WIDTH-1:0]  step_rem;
   logic                  advance;
   logic                  accept_in;

   assign csr_ready = 1'b1;

   ccrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   ccrc_step u_step (
      .cfg       (cfg),
      .rem_i     (rem_ff),
      .data_byte (in_byte_ff),
      .rem_o     (step_rem)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept_in = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end

      rem_in = rem_ff;
      if (advance) begin
         rem_in = in_last_ff ? '0 : step_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         out_rem_ff   <= step_rem;
         out_final_ff <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_remainder = RSP_REM_W'(out_rem_ff);
   assign rsp_is_final  = out_final_ff;

endmodule
`default_nettype wire

/* tb/configurable_crc_remainder_checker.sv */
// Checker for the CRC remainder core: predicts each result beat and compares it.
module configurable_crc_remainder_checker
   import ccrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [RSP_REM_W-1:0]  rsp_remainder,
   input  logic                  rsp_is_final,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    outstanding,
   output int                    fail_count
);

   typedef struct packed {
      logic [RSP_REM_W-1:0] remainder;
      logic                 is_final;
   } crc_result_type;

   crc_result_type        expected_q[$];
   logic [DEG_W-1:0]      degree_cfg;
   logic [LOW_BITS_W-1:0] low_bits_cfg;
   logic [REM_WIDTH-1:0]  running_crc;
   int                    result_count;
   int                    report_count;

   // Eight MSB-first division steps; degree saturates to 1..MAX_DEGREE.
   function automatic logic [RSP_REM_W-1:0] crc_advance(
      input logic [REM_WIDTH-1:0]  crc_in,
      input logic [7:0]            data,
      input logic [DEG_W-1:0]      degree,
      input logic [LOW_BITS_W-1:0] low_bits
   );
      int unsigned width;
      int          b;
      logic [63:0] mask;
      logic [63:0] poly;
      logic [63:0] r;
      logic        top;
      width = degree;
      if (width < 1) width = 1;
      if (width > MAX_DEGREE) width = MAX_DEGREE;
      mask = (64'd1 << width) - 64'd1;
      poly = {32'd0, low_bits} & mask;
      r    = {32'd0, crc_in} & mask;
      for (b = 7; b >= 0; b--) begin
         top = r[width-1];
         r   = (r << 1) & mask;
         if (top ^ data[b]) r = r ^ poly;
      end
      return r[RSP_REM_W-1:0];
   endfunction

   always @(posedge clock) begin
      crc_result_type got;
      crc_result_type want;
      int             delta;
      int             fails;
      delta = 0;
      fails = 0;
      if (reset) begin
         expected_q.delete();
         degree_cfg   = DEGREE_RESET;
         low_bits_cfg = LOW_BITS_RESET;
         running_crc  = '0;
         result_count = 0;
         report_count = 0;
         outstanding <= 0;
         fail_count  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.remainder = rsp_remainder;
            got.is_final  = rsp_is_final;
            if (expected_q.size() == 0) begin
               fails++;
               if (report_count < 10)
                  $display("ERROR result beat %0d: no beat expected, got remainder %h final %b",
                           result_count, got.remainder, got.is_final);
               report_count++;
            end else begin
               want = expected_q.pop_front();
               delta--;
               if (got !== want) begin
                  fails++;
                  if (report_count < 10)
                     $display("ERROR result beat %0d: remainder exp %h got %h, final exp %b got %b",
                              result_count, want.remainder, got.remainder,
                              want.is_final, got.is_final);
                  report_count++;
               end
            end
            result_count++;
         end
         if (req_valid && !req_stall) begin
            want.remainder = crc_advance(running_crc, req_data_byte, degree_cfg, low_bits_cfg);
            want.is_final  = req_last_byte;
            expected_q.push_back(want);
            running_crc = req_last_byte ? '0 : want.remainder;
            delta++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLY_DEGREE:   degree_cfg   = csr_data[DEG_W-1:0];
               CSR_POLY_LOW_BITS: low_bits_cfg = csr_data[LOW_BITS_W-1:0];
               default: ;
            endcase
         end
         outstanding <= outstanding + delta;
         fail_count  <= fail_count + fails;
      end
   end

endmodule

/* tb/tb_configurable_crc_remainder_core.sv */
// Testbench top for the CRC remainder core: clock, reset, stimulus and verdict.
module tb_configurable_crc_remainder_core;
   import ccrc_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RSP_REM_W-1:0]  rsp_remainder;
   logic                  rsp_is_final;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    outstanding;
   int                    fail_count;

   logic                  gaps_on      = 1'b1;
   logic                  hold_pending = 1'b0;
   logic                  hold_active  = 1'b0;
   logic                  quiet_tail   = 1'b0;
   int                    msg_left     = 0;

   configurable_crc_remainder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_remainder (rsp_remainder),
      .rsp_is_final  (rsp_is_final),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   configurable_crc_remainder_checker crc_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_remainder (rsp_remainder),
      .rsp_is_final  (rsp_is_final),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .outstanding   (outstanding),
      .fail_count    (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_beat(input logic [7:0] data, input logic last);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_poly(input logic [DEG_W-1:0] degree, input logic [LOW_BITS_W-1:0] low_bits);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_POLY_DEGREE;
      csr_data  <= ($urandom & ~32'h3F) | CSR_DATA_W'(degree);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_POLY_LOW_BITS;
      csr_data  <= low_bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall bursts, one long hold-off, free-running tail
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (hold_pending) begin
            rsp_stall  <= 1'b1;
            hold_active = 1'b1;
            repeat (300) @(posedge clock);
            hold_active  = 1'b0;
            hold_pending = 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 40)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [7:0]            data;
      logic [DEG_W-1:0]      deg;
      logic [LOW_BITS_W-1:0] low;
      int                    phase;
      int                    n;
      int                    sel;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_POLY_DEGREE;
      csr_data      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset polynomial x^3 + x + 1
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h55, 1'b1);
      // degree zero saturates to one
      load_poly(6'd0, 32'hFFFF_FFFF);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h80, 1'b1);
      // degree above max saturates, empty low bits
      load_poly(6'd63, 32'h0000_0000);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h12, 1'b1);
      // change polynomial in the middle of a message
      load_poly(6'd32, 32'h04C1_1DB7);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h5A, 1'b0);
      load_poly(6'd16, 32'h0000_1021);
      send_beat(8'hC3, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h7E, 1'b1);
      load_poly(6'd33, 32'h8000_0001);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);

      for (phase = 0; phase < 11; phase++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin deg = 6'd3;  low = 32'h0000_0003; end
            1: begin deg = 6'd8;  low = 32'h0000_0007; end
            2: begin deg = 6'd10; low = 32'h0000_0235; end
            3: begin deg = 6'd16; low = 32'h0000_1021; end
            4: begin deg = 6'd32; low = 32'h04C1_1DB7; end
            5: begin deg = 6'd1;  low = $urandom; end
            6: begin deg = 6'(MAX_DEGREE); low = $urandom; end
            7: begin deg = 6'($urandom_range(0, 63)); low = $urandom; end
            8: begin
               deg = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
               low = $urandom;
            end
            default: begin
               deg = 6'($urandom_range(1, 32));
               low = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
         endcase
         load_poly(deg, low);
         gaps_on = ($urandom_range(0, 3) != 0);
         n = 48;
         if (phase == 1) begin
            gaps_on      = 1'b0;
            n            = 70;
            hold_pending = 1'b1;
            while (!hold_active) @(posedge clock);
         end
         if (phase == 10) begin
            gaps_on    = 1'b0;
            quiet_tail = 1'b1;
         end
         repeat (n) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
               0:       data = 8'h00;
               1:       data = 8'hFF;
               default: data = 8'($urandom_range(0, 255));
            endcase
            send_beat(data, msg_left == 1);
            msg_left--;
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("Mismatches found");
      $finish;
   end

endmodule
